>>> hw/rtl/datetime_validate_bcd_encode_defines.svh
// Assertion macros for the checker file of the date and time encoder.
// Each macro samples on the rising edge of clk; the first form is switched
// off while rst_n is low, the second also watches the reset cycles.
`ifndef DATETIME_VALIDATE_BCD_ENCODE_DEFINES_SVH
`define DATETIME_VALIDATE_BCD_ENCODE_DEFINES_SVH

`define DTV_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define DTV_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/dtv_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package dtv_pkg;

  // Stream widths, padded to whole bytes.
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 56;

  // Accepted ranges.
  localparam int unsigned YEAR_MIN   = 2009;
  localparam int unsigned YEAR_MAX   = 2099;
  localparam int unsigned YEAR_BASE  = 2000;
  localparam int unsigned HOUR_MAX   = 23;
  localparam int unsigned MINUTE_MAX = 59;
  localparam int unsigned SECOND_MAX = 59;
  localparam int unsigned MONTH_MAX  = 12;

  localparam logic [3:0] MONTH_FEB = 4'd2;

  // 1901-01-01 is weekday 2, which puts 2000-01-01 on weekday 6.
  localparam int unsigned JAN1_BASE_WEEKDAY = 6;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [5:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } dtv_item_t;

  typedef struct packed {
    logic       valid_res;
    logic [2:0] weekday;
    logic [7:0] second_bcd;
    logic [7:0] minute_bcd;
    logic [7:0] hour_bcd;
    logic [7:0] day_bcd;
    logic [7:0] month_bcd;
    logic [7:0] year_bcd;
  } dtv_res_t;

  function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
    logic [4:0] len;
    begin
      case (month) inside
        4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
        MONTH_FEB:               len = leap ? 5'd29 : 5'd28;
        default:                 len = 5'd31;
      endcase
      return len;
    end
  endfunction

  // Days before the first of the month, reduced modulo 7.
  function automatic logic [2:0] dbm_mod7(input logic [3:0] month);
    logic [2:0] r;
    begin
      case (month)
        4'd1:    r = 3'd0;
        4'd2:    r = 3'd3;
        4'd3:    r = 3'd3;
        4'd4:    r = 3'd6;
        4'd5:    r = 3'd1;
        4'd6:    r = 3'd4;
        4'd7:    r = 3'd6;
        4'd8:    r = 3'd2;
        4'd9:    r = 3'd5;
        4'd10:   r = 3'd0;
        4'd11:   r = 3'd3;
        4'd12:   r = 3'd5;
        default: r = 3'd0;
      endcase
      return r;
    end
  endfunction

  // Remainder by 7 of a byte: 64 and 8 are both 1 modulo 7, so the value is
  // folded twice and then corrected by at most two subtractions.
  function automatic logic [2:0] mod7(input logic [7:0] v);
    logic [6:0] f1;
    logic [3:0] f2;
    logic [3:0] f3;
    begin
      f1 = {5'd0, v[7:6]} + {1'b0, v[5:0]};
      f2 = f1[6:3] + {1'b0, f1[2:0]};
      f3 = (f2 >= 4'd7) ? f2 - 4'd7 : f2;
      f3 = (f3 >= 4'd7) ? f3 - 4'd7 : f3;
      return f3[2:0];
    end
  endfunction

  // Two-digit packed BCD; tens come from a multiply by 103/1024, which is
  // exact for every value up to 99.
  function automatic logic [7:0] to_bcd(input logic [6:0] v);
    logic [13:0] prod;
    logic [3:0]  tens;
    logic [6:0]  ones;
    begin
      prod = {7'd0, v} * 14'd103;
      tens = prod[13:10];
      ones = v - ({3'd0, tens} * 7'd10);
      return {tens, ones[3:0]};
    end
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/datetime_validate_bcd_encode.sv
// Date and time checker and BCD encoder.
//
// Each word on the in_ stream carries one binary calendar date and time.
// The block checks it (years 2009 to 2099, real month lengths with leap
// years, hours to 23, minutes and seconds to 59), works out the day of week
// and returns one word on the out_ stream with the packed BCD bytes of every
// field. out_tuser is set for a date and time that passed; when it is clear
// the whole of out_tdata is zero.
//
// The word is captured in an input register, checked and encoded by short
// logic, and held in an output register; out_tvalid rises when the word
// reaches the output register. While out_tready is high a new word is
// taken in every cycle, one per cycle sustained by the two-register pipeline.
// When the receiver holds out_tready low the output word stays put, the
// input register still fills once, and in_tready falls only when both
// registers are full. A synchronous low on rst_n empties both registers;
// no word is lost or repeated across a stall.
`timescale 1ns / 1ps
`default_nettype none

module datetime_validate_bcd_encode import dtv_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // year [11:0], month [15:12], day [21:16], hour [26:22], minute [32:27],
  // second [38:33], bit 39 unused
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // weekday [2:0], second_bcd [10:3], minute_bcd [18:11], hour_bcd [26:19],
  // day_bcd [34:27], month_bcd [42:35], year_bcd [50:43], [55:51] zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // valid_res [0]
  output logic                   out_tuser
);

  logic      in_valid_r;
  logic      in_valid_nxt;
  dtv_item_t item_r;
  dtv_item_t item_in;
  logic      out_valid_r;
  logic      out_valid_nxt;
  dtv_res_t  res_r;
  dtv_res_t  res_calc;
  logic      out_free;
  logic      in_take;
  logic      move;

  // Unpack the stream word, first field in the lowest bits.
  assign item_in.year   = in_tdata[11:0];
  assign item_in.month  = in_tdata[15:12];
  assign item_in.day    = in_tdata[21:16];
  assign item_in.hour   = in_tdata[26:22];
  assign item_in.minute = in_tdata[32:27];
  assign item_in.second = in_tdata[38:33];

  // The output register can take a word when it is empty or being drained.
  assign out_free  = !out_valid_r || out_tready;
  assign move      = in_valid_r && out_free;
  assign in_tready = !in_valid_r || out_free;
  assign in_take   = in_tvalid && in_tready;

  dtv_calc u_calc (
    .item (item_r),
    .res  (res_calc)
  );

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (move) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (move) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers load without reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r <= item_in;
    end
    if (move) begin
      res_r <= res_calc;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = res_r.valid_res;
  assign out_tdata  = {5'd0, res_r.year_bcd, res_r.month_bcd, res_r.day_bcd,
                       res_r.hour_bcd, res_r.minute_bcd, res_r.second_bcd,
                       res_r.weekday};

endmodule

`default_nettype wire

>>> hw/rtl/dtv_calc.sv
`timescale 1ns / 1ps
`default_nettype none

// Range checks, day of week and BCD packing for one date and time.
module dtv_calc import dtv_pkg::*; (
  input  dtv_item_t item,
  output dtv_res_t  res
);

  logic [11:0] year_off;
  logic [6:0]  yy;
  logic        leap;
  logic        year_ok;
  logic        month_ok;
  logic        day_ok;
  logic        time_ok;
  logic        ok;
  logic [4:0]  mlen;
  logic [7:0]  yy_plus3;
  logic [5:0]  leap_cnt;
  logic        feb_passed;
  logic [7:0]  dow_sum;

  assign year_off = item.year - 12'(YEAR_BASE);
  assign yy       = year_off[6:0];

  // Inside the accepted years the century rule never applies.
  assign leap     = (item.year[1:0] == 2'b00);

  assign year_ok  = (item.year >= 12'(YEAR_MIN)) && (item.year <= 12'(YEAR_MAX));
  assign month_ok = (item.month != 4'd0) && (item.month <= 4'(MONTH_MAX));
  assign mlen     = month_len(item.month, leap);
  assign day_ok   = (item.day != 6'd0) && (item.day <= {1'b0, mlen});
  assign time_ok  = (item.hour <= 5'(HOUR_MAX)) && (item.minute <= 6'(MINUTE_MAX)) &&
                    (item.second <= 6'(SECOND_MAX));
  assign ok       = year_ok && month_ok && day_ok && time_ok;

  // Leap days from 2000-01-01 up to the first of January of this year.
  assign yy_plus3   = {1'b0, yy} + 8'd3;
  assign leap_cnt   = yy_plus3[7:2];
  assign feb_passed = (item.month > MONTH_FEB) && leap;

  // 365 is 1 modulo 7, so each year moves the weekday by one.
  assign dow_sum = 8'(JAN1_BASE_WEEKDAY - 1) + {1'b0, yy} + {2'b00, leap_cnt} +
                   {5'd0, dbm_mod7(item.month)} + {2'b00, item.day} +
                   {7'd0, feb_passed};

  always_comb begin
    res = '0;
    if (ok) begin
      res.valid_res  = 1'b1;
      res.weekday    = mod7(dow_sum);
      res.second_bcd = to_bcd({1'b0, item.second});
      res.minute_bcd = to_bcd({1'b0, item.minute});
      res.hour_bcd   = to_bcd({2'b00, item.hour});
      res.day_bcd    = to_bcd({1'b0, item.day});
      res.month_bcd  = to_bcd({3'd0, item.month});
      res.year_bcd   = to_bcd(yy);
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/dtv_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "datetime_validate_bcd_encode_defines.svh"

// Watches the output ports of the encoder.
module dtv_checker import dtv_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  // A stalled result word stays offered and unchanged.
  `DTV_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid,
    "result word dropped while stalled")
  `DTV_ASSERT(a_out_stable,
    out_tvalid && !out_tready |=> $stable(out_tdata) && $stable(out_tuser),
    "result word changed while stalled")

  // Reset empties the pipeline.
  `DTV_ASSERT_RST(a_reset_empty, $past(!rst_n) |-> !out_tvalid,
    "result offered straight after reset")

  // A rejected date carries an all-zero word.
  `DTV_ASSERT(a_reject_zero, out_tvalid && !out_tuser |-> out_tdata == '0,
    "rejected date has nonzero fields")

  // An accepted date carries decimal ones digits in every field, a decimal year tens digit and a weekday below 7.
  `DTV_ASSERT(a_digits,
    out_tvalid && out_tuser |-> out_tdata[2:0] != 3'd7 &&
      out_tdata[6:3] <= 4'd9 && out_tdata[14:11] <= 4'd9 &&
      out_tdata[22:19] <= 4'd9 && out_tdata[30:27] <= 4'd9 &&
      out_tdata[38:35] <= 4'd9 && out_tdata[46:43] <= 4'd9 &&
      out_tdata[50:47] <= 4'd9 && out_tdata[55:51] == 5'd0,
    "accepted date has a digit out of range")

endmodule

bind datetime_validate_bcd_encode dtv_checker u_dtv_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
